// ===== sv/tle_pkg.sv =====
// tle_pkg: shared sizes, byte codes, command/status types for the terminal line editor.
// Used by tle_ctrl, tle_dp and terminal_line_editor. No dependencies.
package tle_pkg;

    // Storage sizes
    localparam int LINE_MAX  = 64;
    localparam int ESC_DEPTH = 16;
    localparam int LIMIT_MIN = 16;

    localparam int LC_W   = $clog2(LINE_MAX + 1);   // line count, holds LINE_MAX
    localparam int LA_W   = $clog2(LINE_MAX);       // line store address
    localparam int ESC_AW = $clog2(ESC_DEPTH);      // escape store address
    localparam int ESC_CW = $clog2(ESC_DEPTH + 1);  // escape count, holds ESC_DEPTH
    localparam int CMP_W  = (LC_W > 7) ? LC_W : 7;  // compare width for limits/indexes

    // Input operation codes
    localparam logic OP_RX   = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Configuration register indexes
    localparam logic CFG_LOCAL_ECHO = 1'b0;
    localparam logic CFG_LINE_LIMIT = 1'b1;

    // Terminal byte codes
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_CAN      = 8'h18;
    localparam logic [7:0] CH_SUB      = 8'h1A;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_CTL_MAX  = 8'h1F;
    localparam logic [7:0] CH_SP       = 8'h20;
    localparam logic [7:0] CH_FIN_LO   = 8'h40;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_FE_HI    = 8'h5F;
    localparam logic [7:0] CH_FIN_HI   = 8'h7E;
    localparam logic [7:0] CH_DEL      = 8'h7F;

    typedef enum logic [1:0] {
        K_BYTE   = 2'd0,
        K_READY  = 2'd1,
        K_PROMPT = 2'd2,
        K_READ   = 2'd3
    } t_kind;

    // Output byte source
    typedef enum logic [1:0] {
        B_CONST,
        B_ECHO,
        B_ESC,
        B_LINE
    } t_bsel;

    typedef enum logic [1:0] {
        LC_HOLD,
        LC_ZERO,
        LC_INC,
        LC_DEC
    } t_lc_op;

    typedef enum logic [1:0] {
        ESC_HOLD,
        ESC_CLR,
        ESC_ONE,
        ESC_PUSH
    } t_esc_op;

    typedef struct packed {
        logic       en;
        t_kind      kind;
        t_bsel      bsel;
        logic [7:0] cbyte;
        logic       len_en;
        logic       last;
    } t_emit;

    typedef struct packed {
        logic    take;     // input transfer this cycle
        logic    fresh;    // line count reads as zero (first byte after reset)
        t_lc_op  lc_op;
        logic    line_wr;
        t_esc_op esc_op;
        logic    step;     // advance replay index
        t_emit   emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic lc_nz;
        logic lc_room;
        logic echo;
        logic esc_full;
        logic esc_pos1;
        logic rep_end;
    } t_stat;

endpackage

// ===== sv/tle_ram.sv =====
// tle_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/tle_dp.sv =====
// tle_dp: line editor datapath - config registers, counts, line and escape
// stores, replay index and the output register. Depends on tle_pkg, tle_ram.
module tle_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tle_pkg::t_cmd        i_cmd,
    output tle_pkg::t_stat       o_stat,
    input  logic [7:0]           i_in_byte,
    input  logic [5:0]           i_read_index,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_addr,
    input  logic [6:0]           i_cfg_wdata,
    input  logic                 i_ready,
    output logic                 o_valid,
    output tle_pkg::t_kind       o_out_kind,
    output logic [7:0]           o_out_byte,
    output logic [6:0]           o_line_length,
    output logic                 o_last
);

    logic                       r_local_echo;
    logic [6:0]                 r_line_limit;
    logic [tle_pkg::LC_W-1:0]   r_line_count, n_line_count;
    logic [tle_pkg::ESC_CW-1:0] r_esc_cnt, n_esc_cnt;
    logic [tle_pkg::ESC_AW-1:0] r_idx, n_idx;
    logic [tle_pkg::ESC_AW-1:0] r_rep_last;
    logic [tle_pkg::LA_W-1:0]   r_ra, n_ra;
    logic                       r_oob;
    logic [7:0]                 r_byte;
    logic [tle_pkg::LC_W-1:0]   r_len;

    logic                       r_out_valid, n_out_valid;
    tle_pkg::t_kind             r_out_kind;
    logic [7:0]                 r_out_byte;
    logic [6:0]                 r_out_len;
    logic                       r_out_last;

    logic [tle_pkg::LC_W-1:0]   lc_eff;
    logic [tle_pkg::CMP_W-1:0]  lim, eff_lim;
    logic [7:0]                 line_rd, esc_rd, sel_byte;
    logic                       out_free, load;

    // effective limit, clamped to LIMIT_MIN..LINE_MAX
    always_comb begin
        lim = tle_pkg::CMP_W'(r_line_limit);
        if (lim < tle_pkg::CMP_W'(tle_pkg::LIMIT_MIN)) begin
            eff_lim = tle_pkg::CMP_W'(tle_pkg::LIMIT_MIN);
        end else if (lim > tle_pkg::CMP_W'(tle_pkg::LINE_MAX)) begin
            eff_lim = tle_pkg::CMP_W'(tle_pkg::LINE_MAX);
        end else begin
            eff_lim = lim;
        end
    end

    assign lc_eff   = i_cmd.fresh ? '0 : r_line_count;
    assign out_free = !r_out_valid || i_ready;
    assign load     = i_cmd.emit.en && out_free;

    assign o_stat.out_free = out_free;
    assign o_stat.lc_nz    = (lc_eff != '0);
    assign o_stat.lc_room  = (tle_pkg::CMP_W'(lc_eff) < eff_lim);
    assign o_stat.echo     = r_local_echo;
    assign o_stat.esc_full = (r_esc_cnt == tle_pkg::ESC_CW'(tle_pkg::ESC_DEPTH));
    assign o_stat.esc_pos1 = (r_esc_cnt == tle_pkg::ESC_CW'(1));
    assign o_stat.rep_end  = (r_idx == r_rep_last);

    always_comb begin
        n_line_count = r_line_count;
        n_esc_cnt    = r_esc_cnt;
        if (i_cmd.take) begin
            unique case (i_cmd.lc_op)
                tle_pkg::LC_HOLD: n_line_count = lc_eff;
                tle_pkg::LC_ZERO: n_line_count = '0;
                tle_pkg::LC_INC:  n_line_count = lc_eff + tle_pkg::LC_W'(1);
                tle_pkg::LC_DEC:  n_line_count = lc_eff - tle_pkg::LC_W'(1);
            endcase
            unique case (i_cmd.esc_op)
                tle_pkg::ESC_HOLD: n_esc_cnt = r_esc_cnt;
                tle_pkg::ESC_CLR:  n_esc_cnt = '0;
                tle_pkg::ESC_ONE:  n_esc_cnt = tle_pkg::ESC_CW'(1);
                tle_pkg::ESC_PUSH: n_esc_cnt = r_esc_cnt + tle_pkg::ESC_CW'(1);
            endcase
        end
    end

    // Read addresses come from next-value logic so the registered RAM data
    // always matches the current index register.
    always_comb begin
        if (i_cmd.take) begin
            n_idx = '0;
        end else if (i_cmd.step) begin
            n_idx = r_idx + tle_pkg::ESC_AW'(1);
        end else begin
            n_idx = r_idx;
        end
        n_ra = i_cmd.take ? tle_pkg::LA_W'(i_read_index) : r_ra;
    end

    tle_ram #(.WIDTH(8), .DEPTH(tle_pkg::LINE_MAX)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take && i_cmd.line_wr),
        .i_waddr (tle_pkg::LA_W'(lc_eff)),
        .i_wdata (i_in_byte),
        .i_raddr (n_ra),
        .o_rdata (line_rd)
    );

    // entry 0 is never written; replay supplies ESC in its place
    tle_ram #(.WIDTH(8), .DEPTH(tle_pkg::ESC_DEPTH)) u_esc_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.take && (i_cmd.esc_op == tle_pkg::ESC_PUSH)),
        .i_waddr (tle_pkg::ESC_AW'(r_esc_cnt)),
        .i_wdata (i_in_byte),
        .i_raddr (n_idx),
        .o_rdata (esc_rd)
    );

    always_comb begin
        unique case (i_cmd.emit.bsel)
            tle_pkg::B_CONST: sel_byte = i_cmd.emit.cbyte;
            tle_pkg::B_ECHO:  sel_byte = r_byte;
            tle_pkg::B_ESC:   sel_byte = (r_idx == '0) ? tle_pkg::CH_ESC : esc_rd;
            tle_pkg::B_LINE:  sel_byte = r_oob ? 8'h00 : line_rd;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_echo <= 1'b1;
            r_line_limit <= 7'd64;
            r_line_count <= '0;
            r_esc_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    tle_pkg::CFG_LOCAL_ECHO: r_local_echo <= i_cfg_wdata[0];
                    tle_pkg::CFG_LINE_LIMIT: r_line_limit <= i_cfg_wdata;
                endcase
            end
            r_line_count <= n_line_count;
            r_esc_cnt    <= n_esc_cnt;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_ra  <= n_ra;
        if (i_cmd.take) begin
            r_byte     <= i_in_byte;
            r_len      <= lc_eff;
            r_rep_last <= tle_pkg::ESC_AW'(r_esc_cnt - tle_pkg::ESC_CW'(1));
            r_oob      <= (tle_pkg::CMP_W'(i_read_index) >= tle_pkg::CMP_W'(tle_pkg::LINE_MAX));
        end
        if (load) begin
            r_out_kind <= i_cmd.emit.kind;
            r_out_byte <= sel_byte;
            r_out_len  <= i_cmd.emit.len_en ? 7'(r_len) : 7'd0;
            r_out_last <= i_cmd.emit.last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_kind    = r_out_kind;
    assign o_out_byte    = r_out_byte;
    assign o_line_length = r_out_len;
    assign o_last        = r_out_last;

    a_lc_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_count <= tle_pkg::LC_W'(tle_pkg::LINE_MAX))
        else $error("line count above store size");

    a_esc_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc_cnt <= tle_pkg::ESC_CW'(tle_pkg::ESC_DEPTH))
        else $error("escape count above store size");

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_idx != r_rep_last))
        else $error("replay index stepped past last stored byte");

endmodule

// ===== sv/tle_ctrl.sv =====
// tle_ctrl: line editor sequencer - decodes each input byte, keeps the phase
// and walks the result sequence. Depends on tle_pkg.
module tle_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_operation,
    input  logic [7:0]     i_in_byte,
    input  tle_pkg::t_stat i_stat,
    output tle_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_PROMPT,
        S_REPLAY,
        S_CR,
        S_LF,
        S_READY,
        S_PEND,
        S_BS1,
        S_SP,
        S_BS2,
        S_ECHO
    } t_state;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_EDIT,
        PH_ESC
    } t_phase;

    typedef enum logic [1:0] {
        E_NONE,
        E_CR,
        E_BS,
        E_ECHO
    } t_edit;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    t_edit  r_edit, n_edit;

    // edit-phase decode of the incoming byte
    t_edit           e_act;
    tle_pkg::t_lc_op e_lc;
    logic            e_wr;
    logic            e_esc;
    logic            seq_done;
    logic            is_cancel;
    logic [7:0]      c;

    function automatic t_state edit_entry(input t_edit act);
        t_state s;
        unique case (act)
            E_NONE: s = S_IDLE;
            E_CR:   s = S_CR;
            E_BS:   s = S_BS1;
            E_ECHO: s = S_ECHO;
        endcase
        return s;
    endfunction

    assign c         = i_in_byte;
    assign is_cancel = (c == tle_pkg::CH_CAN) || (c == tle_pkg::CH_SUB);

    // Fe final at position 1 (not CSI), any final byte later on
    assign seq_done = i_stat.esc_pos1
        ? (c != tle_pkg::CH_LBRACKET && c >= tle_pkg::CH_FIN_LO && c <= tle_pkg::CH_FE_HI)
        : (c >= tle_pkg::CH_FIN_LO && c <= tle_pkg::CH_FIN_HI);

    always_comb begin
        e_act = E_NONE;
        e_lc  = tle_pkg::LC_HOLD;
        e_wr  = 1'b0;
        e_esc = 1'b0;
        priority if (c == tle_pkg::CH_CR) begin
            e_act = E_CR;
            e_lc  = tle_pkg::LC_ZERO;
        end else if (c == tle_pkg::CH_BS || c == tle_pkg::CH_DEL) begin
            if (i_stat.lc_nz) begin
                e_act = E_BS;
                e_lc  = tle_pkg::LC_DEC;
            end
        end else if (c == tle_pkg::CH_ESC) begin
            e_esc = 1'b1;
        end else if (c > tle_pkg::CH_CTL_MAX && c < tle_pkg::CH_DEL) begin
            if (i_stat.lc_room) begin
                e_wr  = 1'b1;
                e_lc  = tle_pkg::LC_INC;
                e_act = i_stat.echo ? E_ECHO : E_NONE;
            end
        end else begin
            e_act = E_NONE;   // other control bytes and high bytes
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_edit  = r_edit;

        o_cmd             = '0;
        o_cmd.fresh       = (r_phase == PH_WAIT);
        o_cmd.lc_op       = tle_pkg::LC_HOLD;
        o_cmd.esc_op      = tle_pkg::ESC_HOLD;
        o_cmd.emit.kind   = tle_pkg::K_BYTE;
        o_cmd.emit.bsel   = tle_pkg::B_CONST;
        o_cmd.emit.cbyte  = 8'h00;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_operation == tle_pkg::OP_READ) begin
                        n_state = S_READ;
                    end else if (r_phase == PH_ESC) begin
                        if (is_cancel) begin
                            o_cmd.esc_op = tle_pkg::ESC_CLR;
                            n_phase      = PH_EDIT;
                            n_edit       = E_NONE;
                            n_state      = S_REPLAY;
                        end else if (!i_stat.esc_full) begin
                            if (seq_done) begin
                                o_cmd.esc_op = tle_pkg::ESC_CLR;
                                n_phase      = PH_EDIT;
                            end else begin
                                o_cmd.esc_op = tle_pkg::ESC_PUSH;
                            end
                        end else begin
                            // overflow: replay, then edit with this byte
                            o_cmd.esc_op  = e_esc ? tle_pkg::ESC_ONE : tle_pkg::ESC_CLR;
                            o_cmd.lc_op   = e_lc;
                            o_cmd.line_wr = e_wr;
                            n_phase       = e_esc ? PH_ESC : PH_EDIT;
                            n_edit        = e_act;
                            n_state       = S_REPLAY;
                        end
                    end else begin
                        o_cmd.lc_op   = e_lc;
                        o_cmd.line_wr = e_wr;
                        if (e_esc) begin
                            o_cmd.esc_op = tle_pkg::ESC_ONE;
                            n_phase      = PH_ESC;
                        end else begin
                            n_phase = PH_EDIT;
                        end
                        n_edit  = e_act;
                        n_state = (r_phase == PH_WAIT) ? S_PROMPT : edit_entry(e_act);
                    end
                end
            end
            S_READ: begin
                o_cmd.emit.en   = 1'b1;
                o_cmd.emit.kind = tle_pkg::K_READ;
                o_cmd.emit.bsel = tle_pkg::B_LINE;
                o_cmd.emit.last = 1'b1;
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_PROMPT: begin
                o_cmd.emit.en   = 1'b1;
                o_cmd.emit.kind = tle_pkg::K_PROMPT;
                o_cmd.emit.last = (r_edit == E_NONE);
                if (i_stat.out_free) n_state = edit_entry(r_edit);
            end
            S_REPLAY: begin
                o_cmd.emit.en   = 1'b1;
                o_cmd.emit.bsel = tle_pkg::B_ESC;
                o_cmd.emit.last = i_stat.rep_end && (r_edit == E_NONE);
                if (i_stat.out_free) begin
                    if (i_stat.rep_end) begin
                        n_state = edit_entry(r_edit);
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            S_CR: begin
                o_cmd.emit.en    = 1'b1;
                o_cmd.emit.cbyte = tle_pkg::CH_CR;
                if (i_stat.out_free) n_state = S_LF;
            end
            S_LF: begin
                o_cmd.emit.en    = 1'b1;
                o_cmd.emit.cbyte = tle_pkg::CH_LF;
                if (i_stat.out_free) n_state = S_READY;
            end
            S_READY: begin
                o_cmd.emit.en     = 1'b1;
                o_cmd.emit.kind   = tle_pkg::K_READY;
                o_cmd.emit.len_en = 1'b1;
                if (i_stat.out_free) n_state = S_PEND;
            end
            S_PEND: begin
                o_cmd.emit.en   = 1'b1;
                o_cmd.emit.kind = tle_pkg::K_PROMPT;
                o_cmd.emit.last = 1'b1;
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_BS1: begin
                o_cmd.emit.en    = 1'b1;
                o_cmd.emit.cbyte = tle_pkg::CH_BS;
                if (i_stat.out_free) n_state = S_SP;
            end
            S_SP: begin
                o_cmd.emit.en    = 1'b1;
                o_cmd.emit.cbyte = tle_pkg::CH_SP;
                if (i_stat.out_free) n_state = S_BS2;
            end
            S_BS2: begin
                o_cmd.emit.en    = 1'b1;
                o_cmd.emit.cbyte = tle_pkg::CH_BS;
                o_cmd.emit.last  = 1'b1;
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_ECHO: begin
                o_cmd.emit.en   = 1'b1;
                o_cmd.emit.bsel = tle_pkg::B_ECHO;
                o_cmd.emit.last = 1'b1;
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_WAIT;
            r_edit  <= E_NONE;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_edit  <= n_edit;
        end
    end

    a_wait_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_WAIT) |=> (r_phase != PH_WAIT))
        else $error("returned to waiting phase without reset");

    a_read_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid && i_operation == tle_pkg::OP_READ) |=> (r_state == S_READ))
        else $error("read transfer did not start a read result");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |-> !o_cmd.emit.en)
        else $error("input taken while a result is being issued");

endmodule

// ===== sv/terminal_line_editor.sv =====
// terminal_line_editor: top level of the terminal line editor.
// Depends on tle_pkg, tle_ctrl, tle_dp (and tle_ram through tle_dp).
//
// Input channel (i_valid/o_ready): operation 0 passes one received terminal
// byte (i_in_byte), operation 1 reads line store entry i_read_index.
// Output channel (o_valid/i_ready): one result per transfer; o_out_kind is
// terminal byte, line ready (with o_line_length), prompt request or read data,
// and o_last marks the final result of an input item. Ignored bytes, bytes
// stored without echo and bytes swallowed by an escape sequence give no result.
// Config port: i_cfg_we writes i_cfg_wdata to register i_cfg_addr (0 local
// echo, 1 line limit) at the clock edge; write only while idle.
// Timing: an item is taken in the idle state, then the sequencer issues each of its
// results (0..ESC_DEPTH+4) in turn into the output register, waiting while that
// register is full; no new item is taken until the last result is loaded. For an
// item with results, the transfer moves the sequencer into the state that loads the first.
// Reset: synchronous; phase goes to waiting for client, counts to zero, local
// echo on and line limit 64. The first received byte yields a prompt request.
// Stall: with i_ready low the sequencer waits on the full output register and
// o_ready stays low until the item's last result is in the register.
module terminal_line_editor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input items
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_operation,
    input  logic [7:0] i_in_byte,
    input  logic [5:0] i_read_index,
    // results
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_out_kind,
    output logic [7:0] o_out_byte,
    output logic [6:0] o_line_length,
    output logic       o_last,
    // configuration writes
    input  logic       i_cfg_we,
    input  logic       i_cfg_addr,
    input  logic [6:0] i_cfg_wdata
);

    tle_pkg::t_cmd  cmd;
    tle_pkg::t_stat stat;
    tle_pkg::t_kind out_kind;

    // sequencer: phase, byte decode, result order
    tle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_in_byte   (i_in_byte),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // storage, counts and output register
    tle_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_in_byte     (i_in_byte),
        .i_read_index  (i_read_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_out_kind    (out_kind),
        .o_out_byte    (o_out_byte),
        .o_line_length (o_line_length),
        .o_last        (o_last)
    );

    assign o_out_kind = out_kind;

endmodule

// ===== verif/tb_terminal_line_editor.sv =====
// tb_terminal_line_editor: self-checking testbench for the terminal line editor.
// Drives byte and read transfers, predicts every result in a local line editor model
// and checks them in order. Depends on tle_pkg and terminal_line_editor.
module tb_terminal_line_editor;

    // Editor phases as the predictor tracks them
    typedef enum logic [1:0] {
        WAIT_CLIENT,
        EDITING,
        IN_ESCAPE
    } t_editor_phase;

    // One input transfer
    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic [5:0] idx;
    } t_term_item;

    // One result transfer
    typedef struct packed {
        tle_pkg::t_kind kind;
        logic [7:0]     data;
        logic [6:0]     length;
        logic           last;
    } t_editor_out;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic       o_ready;
    logic       i_operation   = tle_pkg::OP_RX;
    logic [7:0] i_in_byte     = 8'h00;
    logic [5:0] i_read_index  = 6'd0;
    logic       o_valid;
    logic       i_ready       = 1'b0;
    logic [1:0] o_out_kind;
    logic [7:0] o_out_byte;
    logic [6:0] o_line_length;
    logic       o_last;
    logic       i_cfg_we      = 1'b0;
    logic       i_cfg_addr    = tle_pkg::CFG_LOCAL_ECHO;
    logic [6:0] i_cfg_wdata   = 7'd0;

    terminal_line_editor DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_operation   (i_operation),
        .i_in_byte     (i_in_byte),
        .i_read_index  (i_read_index),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_kind    (o_out_kind),
        .o_out_byte    (o_out_byte),
        .o_line_length (o_line_length),
        .o_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus and checking state
    // ------------------------------------------------------------------
    t_term_item  terminal_rx_q[$];   // bytes/reads waiting for the driver
    t_editor_out editor_out_q[$];    // results still owed by the block
    t_editor_out item_results[$];    // scratch: results of the item being predicted
    t_term_item  cur_item;           // item currently offered on the input channel
    int          bytes_queued = 0;
    logic        failed       = 1'b0;
    logic        calm         = 1'b0;  // no idling on either side
    logic        backlog_req  = 1'b0;  // kicks off the long receiver hold
    logic        rx_hold      = 1'b0;

    // ------------------------------------------------------------------
    // Line editor predictor: own copy of registers and state
    // ------------------------------------------------------------------
    logic                         cfg_echo  = 1'b1;
    logic [6:0]                   cfg_limit = 7'd64;
    t_editor_phase                ed_phase  = WAIT_CLIENT;
    logic [7:0]                   line_buf [tle_pkg::LINE_MAX];
    logic [tle_pkg::LINE_MAX-1:0] line_written = '0;  // entries ever stored since reset
    logic [tle_pkg::LC_W-1:0]     line_count = '0;
    logic [7:0]                   esc_buf [tle_pkg::ESC_DEPTH];
    logic [tle_pkg::ESC_CW-1:0]   esc_count = '0;

    function automatic int active_limit();
        if (int'(cfg_limit) < tle_pkg::LIMIT_MIN) return tle_pkg::LIMIT_MIN;
        if (int'(cfg_limit) > tle_pkg::LINE_MAX) return tle_pkg::LINE_MAX;
        return int'(cfg_limit);
    endfunction

    task automatic emit_out(input tle_pkg::t_kind k, input logic [7:0] b,
                            input logic [6:0] len);
        t_editor_out r;
        r.kind   = k;
        r.data   = b;
        r.length = len;
        r.last   = 1'b0;
        item_results.push_back(r);
    endtask

    // Replay the collected sequence as raw terminal bytes and go back to editing
    task automatic escape_dump();
        for (int i = 0; i < int'(esc_count); i++)
            emit_out(tle_pkg::K_BYTE, esc_buf[tle_pkg::ESC_AW'(i)], 7'd0);
        esc_count = '0;
        ed_phase  = EDITING;
    endtask

    task automatic line_edit(input logic [7:0] c);
        if (c == tle_pkg::CH_CR) begin
            emit_out(tle_pkg::K_BYTE, tle_pkg::CH_CR, 7'd0);
            emit_out(tle_pkg::K_BYTE, tle_pkg::CH_LF, 7'd0);
            emit_out(tle_pkg::K_READY, 8'h00, line_count);
            emit_out(tle_pkg::K_PROMPT, 8'h00, 7'd0);
            line_count = '0;
        end else if (c == tle_pkg::CH_BS || c == tle_pkg::CH_DEL) begin
            if (line_count != '0) begin
                emit_out(tle_pkg::K_BYTE, tle_pkg::CH_BS, 7'd0);
                emit_out(tle_pkg::K_BYTE, tle_pkg::CH_SP, 7'd0);
                emit_out(tle_pkg::K_BYTE, tle_pkg::CH_BS, 7'd0);
                line_count = line_count - 1'b1;
            end
        end else if (c == tle_pkg::CH_ESC) begin
            esc_buf[0] = tle_pkg::CH_ESC;
            esc_count  = tle_pkg::ESC_CW'(1);
            ed_phase   = IN_ESCAPE;
        end else if (c > tle_pkg::CH_CTL_MAX && c < tle_pkg::CH_DEL) begin
            if (int'(line_count) < active_limit()) begin
                line_buf[tle_pkg::LA_W'(line_count)]     = c;
                line_written[tle_pkg::LA_W'(line_count)] = 1'b1;
                line_count                               = line_count + 1'b1;
                if (cfg_echo) emit_out(tle_pkg::K_BYTE, c, 7'd0);
            end
        end
        // other control bytes and 0x80..0xFF fall through: nothing happens
    endtask

    task automatic escape_absorb(input logic [7:0] c);
        int   pos;
        logic ends;
        if (c == tle_pkg::CH_CAN || c == tle_pkg::CH_SUB) begin
            escape_dump();
        end else if (int'(esc_count) < tle_pkg::ESC_DEPTH) begin
            pos                            = int'(esc_count);
            esc_buf[tle_pkg::ESC_AW'(pos)] = c;
            esc_count                      = esc_count + 1'b1;
            // right after ESC only an Fe byte (not CSI) ends it; later any final byte
            if (pos == 1)
                ends = (c != tle_pkg::CH_LBRACKET) && (c >= tle_pkg::CH_FIN_LO) &&
                       (c <= tle_pkg::CH_FE_HI);
            else
                ends = (c >= tle_pkg::CH_FIN_LO) && (c <= tle_pkg::CH_FIN_HI);
            if (ends) begin
                esc_count = '0;
                ed_phase  = EDITING;
            end
        end else begin
            // sequence too long: dump it, then treat the byte as a normal one
            escape_dump();
            line_edit(c);
        end
    endtask

    // Work out every result of one accepted item and queue them up
    task automatic editor_predict(input t_term_item it);
        t_editor_out r;
        item_results.delete();
        if (it.op == tle_pkg::OP_READ) begin
            emit_out(tle_pkg::K_READ, line_buf[it.idx], 7'd0);
        end else if (ed_phase == IN_ESCAPE) begin
            escape_absorb(it.data);
        end else begin
            if (ed_phase == WAIT_CLIENT) begin
                emit_out(tle_pkg::K_PROMPT, 8'h00, 7'd0);
                line_count = '0;
                ed_phase   = EDITING;
            end
            line_edit(it.data);
        end
        if (item_results.size() != 0) begin
            r      = item_results.pop_back();
            r.last = 1'b1;
            item_results.push_back(r);
        end
        foreach (item_results[i]) editor_out_q.push_back(item_results[i]);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued items, random gaps between transfers
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) editor_predict(cur_item);
            // valid only drops or changes once the current transfer has happened
            if (!i_valid || o_ready) begin
                if (terminal_rx_q.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
                    cur_item     = terminal_rx_q.pop_front();
                    i_valid      <= 1'b1;
                    i_operation  <= cur_item.op;
                    i_in_byte    <= cur_item.data;
                    i_read_index <= cur_item.idx;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, or a long hold while backlog runs
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (rx_hold) begin
            i_ready <= 1'b0;
        end else if (calm) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 22);
        end
    end

    // Long hold, counted here so the sender keeps offering items meanwhile
    initial begin
        wait (backlog_req);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: each result transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_editor_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (editor_out_q.size() == 0) begin
                $error("unexpected result: kind %0d byte %02h length %0d last %0d",
                       o_out_kind, o_out_byte, o_line_length, o_last);
                failed <= 1'b1;
            end else begin
                want = editor_out_q.pop_front();
                if (o_out_kind !== want.kind) begin
                    $error("out_kind: expected %0d, got %0d", want.kind, o_out_kind);
                    failed <= 1'b1;
                end
                if (o_out_byte !== want.data) begin
                    $error("out_byte: expected %02h, got %02h", want.data, o_out_byte);
                    failed <= 1'b1;
                end
                if (o_line_length !== want.length) begin
                    $error("line_length: expected %0d, got %0d", want.length, o_line_length);
                    failed <= 1'b1;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    failed <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_item(input logic op, input logic [7:0] b, input logic [5:0] idx);
        t_term_item it;
        it.op   = op;
        it.data = b;
        it.idx  = idx;
        terminal_rx_q.push_back(it);
        bytes_queued++;
    endtask

    // Unused field gets random content so its bits toggle too
    task automatic send_byte(input logic [7:0] b);
        queue_item(tle_pkg::OP_RX, b, 6'($urandom_range(63)));
    endtask

    // Read only entries already stored; the store only ever gains entries, so
    // anything marked here is written before this read gets accepted
    task automatic send_read();
        int pick;
        int k;
        pick = -1;
        repeat (8) begin
            k = int'($urandom_range(tle_pkg::LINE_MAX - 1));
            if (pick < 0 && line_written[tle_pkg::LA_W'(k)]) pick = k;
        end
        for (int j = 0; j < tle_pkg::LINE_MAX; j++)
            if (pick < 0 && line_written[tle_pkg::LA_W'(j)]) pick = j;
        if (pick < 0)
            send_byte(8'h2E);
        else
            queue_item(tle_pkg::OP_READ, 8'($urandom_range(255)), 6'(pick));
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(tle_pkg::CH_FIN_HI, tle_pkg::CH_SP));
    endfunction

    // Intermediate sequence byte: never a final byte, never CAN/SUB
    function automatic logic [7:0] seq_filler();
        if ($urandom_range(9) == 0) return 8'($urandom_range(8'h17, 8'h00));
        return 8'($urandom_range(8'h3F, tle_pkg::CH_SP));
    endfunction

    // ESC + 15 fillers fills the sequence store; the next byte overflows it
    task automatic send_overflow(input logic [7:0] tail);
        send_byte(tle_pkg::CH_ESC);
        repeat (tle_pkg::ESC_DEPTH - 1) send_byte(seq_filler());
        send_byte(tail);
    endtask

    // One random burst: mostly well-formed editing and escape traffic
    task automatic gen_burst();
        int         sel;
        int         n;
        logic [7:0] b;
        sel = int'($urandom_range(99));
        if (sel < 30) begin
            // short text with the odd erase
            n = int'($urandom_range(10, 1));
            repeat (n) begin
                if ($urandom_range(9) == 0)
                    send_byte($urandom_range(1) ? tle_pkg::CH_BS : tle_pkg::CH_DEL);
                else
                    send_byte(printable());
            end
            if ($urandom_range(2) != 0) send_byte(tle_pkg::CH_CR);
        end else if (sel < 40) begin
            // line running up to and past the limit
            n = active_limit() - 2 + int'($urandom_range(6));
            repeat (n) send_byte(printable());
            send_byte(tle_pkg::CH_CR);
        end else if (sel < 60) begin
            send_byte(tle_pkg::CH_ESC);
            if ($urandom_range(3) == 0) begin
                b = 8'($urandom_range(tle_pkg::CH_FE_HI, tle_pkg::CH_FIN_LO));
                if (b == tle_pkg::CH_LBRACKET) b = 8'h4F;
                send_byte(b);
            end else begin
                send_byte(tle_pkg::CH_LBRACKET);
                n = int'($urandom_range(4));
                repeat (n) send_byte(8'($urandom_range(8'h3F, 8'h30)));
                if ($urandom_range(5) == 0) send_read();
                send_byte(8'($urandom_range(tle_pkg::CH_FIN_HI, tle_pkg::CH_FIN_LO)));
            end
        end else if (sel < 68) begin
            // sequence abandoned by CAN or SUB
            send_byte(tle_pkg::CH_ESC);
            n = int'($urandom_range(6));
            repeat (n) send_byte(seq_filler());
            send_byte($urandom_range(1) ? tle_pkg::CH_CAN : tle_pkg::CH_SUB);
        end else if (sel < 74) begin
            send_overflow($urandom_range(2) == 0 ? tle_pkg::CH_CR : 8'($urandom_range(255)));
        end else if (sel < 86) begin
            send_read();
        end else begin
            send_byte(8'($urandom_range(255)));
        end
    endtask

    // Wait until nothing is queued or owed, then let the block settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (terminal_rx_q.size() != 0 || i_valid || editor_out_q.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    // Register write, only ever issued while the block is idle
    task automatic write_reg(input logic addr, input logic [6:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == tle_pkg::CFG_LOCAL_ECHO) cfg_echo = val[0];
        else cfg_limit = val;
    endtask

    task automatic run_phase(input int n_items);
        int goal;
        goal = bytes_queued + n_items;
        while (bytes_queued < goal) begin
            while (terminal_rx_q.size() > 4) @(negedge i_clk);
            gen_burst();
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(tle_pkg::CFG_LOCAL_ECHO, 7'd1);
        write_reg(tle_pkg::CFG_LINE_LIMIT, 7'd64);

        // Directed: first byte after reset, ignored bytes, erase down to empty,
        // sequence endings of each sort, cancel, then a finished line
        send_byte(8'h41);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(tle_pkg::CH_SP);
        send_byte(tle_pkg::CH_FIN_HI);
        queue_item(tle_pkg::OP_READ, 8'h5A, 6'd1);
        send_byte(tle_pkg::CH_CTL_MAX);
        send_byte(tle_pkg::CH_BS);
        send_byte(tle_pkg::CH_DEL);
        send_byte(tle_pkg::CH_BS);
        send_byte(tle_pkg::CH_BS);
        send_byte(tle_pkg::CH_ESC);
        send_byte(tle_pkg::CH_LBRACKET);
        send_byte(8'h41);
        send_byte(tle_pkg::CH_ESC);
        send_byte(8'h4F);
        send_byte(tle_pkg::CH_ESC);
        send_byte(tle_pkg::CH_LBRACKET);
        send_byte(8'h32);
        send_byte(tle_pkg::CH_CAN);
        send_byte(tle_pkg::CH_ESC);
        send_byte(tle_pkg::CH_SUB);
        send_byte(8'h7A);
        send_byte(tle_pkg::CH_CR);
        wait_idle();

        // Overflow on CR gives the longest result burst; this phase runs
        // without any idling on either side
        calm = 1'b1;
        send_overflow(tle_pkg::CH_CR);
        run_phase(58);
        calm = 1'b0;

        write_reg(tle_pkg::CFG_LOCAL_ECHO, 7'd0);
        write_reg(tle_pkg::CFG_LINE_LIMIT, 7'd16);
        run_phase(58);

        // Receiver stalls for a long time while items keep coming
        write_reg(tle_pkg::CFG_LOCAL_ECHO, 7'd1);
        write_reg(tle_pkg::CFG_LINE_LIMIT, 7'd37);
        backlog_req = 1'b1;
        run_phase(58);

        write_reg(tle_pkg::CFG_LOCAL_ECHO, 7'd0);
        write_reg(tle_pkg::CFG_LINE_LIMIT, 7'd63);
        run_phase(58);

        write_reg(tle_pkg::CFG_LOCAL_ECHO, 7'd1);
        write_reg(tle_pkg::CFG_LINE_LIMIT, 7'd64);
        run_phase(58);

        write_reg(tle_pkg::CFG_LINE_LIMIT, 7'd20);
        run_phase(58);

        repeat (20) @(negedge i_clk);
        if (!failed) begin
            $display("terminal_line_editor regression: pass");
        end else begin
            $display("terminal_line_editor regression: fail");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #5000000;
        $display("terminal_line_editor regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/tle_pkg.sv
sv/tle_ram.sv
sv/tle_dp.sv
sv/tle_ctrl.sv
sv/terminal_line_editor.sv
verif/tb_terminal_line_editor.sv
